/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker module
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/swtc_pkg.sv */
// shared types, constants and the reference sine generator of the tone correlator
// no dependencies
package swtc_pkg;

  localparam int unsigned WINDOW_MAX_DEF  = 4096;
  localparam int unsigned TABLE_BITS_DEF  = 10;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned WLEN_W     = 13;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned EN_W       = 48;
  localparam int unsigned QUO_W      = 26;
  localparam int unsigned SQ_W       = 52;
  localparam int unsigned AMP_W      = 24;
  localparam logic [12:0] FILL_MAX   = 13'h1FFF;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_LEN  = 8'd0,
    CFG_PHASE_STEP = 8'd1,
    CFG_WINDOW_LEN = 8'd2,
    CFG_LAG_START  = 8'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_ROM,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_DIV,
    ST_SQ0,
    ST_SQ1,
    ST_ROOT,
    ST_OUT
  } state_e;

  // status of one serial arithmetic unit
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] value;
  } unit_res_t;

  // q15 sine of u/2^(tb-2) quarter turns, series evaluated at elaboration
  function automatic logic [15:0] quarter_sin(input int unsigned u, input int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] s;
    x  = (64'(u) * (PI_Q30 >> 1)) >> (tb - 2);
    x2 = (x * x) >> 30;
    r  = ONE_Q30;
    r  = ONE_Q30 - ((r * x2) >> 30) / 64'd110;
    r  = ONE_Q30 - ((r * x2) >> 30) / 64'd72;
    r  = ONE_Q30 - ((r * x2) >> 30) / 64'd42;
    r  = ONE_Q30 - ((r * x2) >> 30) / 64'd20;
    r  = ONE_Q30 - ((r * x2) >> 30) / 64'd6;
    s  = (r * x) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[15:0];
  endfunction

endpackage

/* hw/rtl/sliding_window_tone_correlator.sv */
// top level of the sliding-window single-bin tone correlator
// depends on swtc_pkg, swtc_ram, swtc_div, swtc_sqrt
//
// Usage:
//   s_axis carries one signed sample per transaction in tdata.
//   m_axis returns one result per sample: tdata holds the amplitude (q.8,
//   saturated), tuser holds the valid flag (window full or length 0, both norms nonzero).
//   cfg writes block_len (0), phase_step (1), window_len (2), lag_start (3);
//   write only while no sample is in flight. cfg_ready_o is always high.
// Sequencing:
//   one sample at a time. A result that is not valid goes to the output
//   after the products; when the oldest sample leaves the window its products
//   are subtracted too: the shared multiplier runs four products per phase,
//   each through the MUL and ACC states. A valid result adds bit-serial
//   division (both in parallel), squaring and serial square root. The next
//   sample is accepted in the cycle after the result is loaded.
// Reset:
//   sums, norms, indexes and fill count clear; the window ram is not cleared
//   and needs no sweep, since an entry is read only after it was written.
// Stall:
//   a finished result waits in the output register; the next sample is still
//   accepted and is worked on until its own result needs the register.
module sliding_window_tone_correlator #(
  parameter int unsigned WINDOW_MAX  = swtc_pkg::WINDOW_MAX_DEF,
  parameter int unsigned TABLE_BITS  = swtc_pkg::TABLE_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = swtc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample stream; tdata: sample
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // result stream; tdata: amplitude; tuser: valid_res
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [swtc_pkg::AMP_W-1:0]          m_axis_tdata,
  output logic [0:0]                          m_axis_tuser,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swtc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [swtc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned PW  = $clog2(WINDOW_MAX);
  localparam int unsigned QN  = 1 << (TABLE_BITS - 2);
  localparam int unsigned MB  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int unsigned PRW = MB + 16;
  localparam int unsigned WW  = swtc_pkg::WLEN_W;
  localparam logic [swtc_pkg::EN_W:0] EN_MAX = {1'b0, {swtc_pkg::EN_W{1'b1}}};

  // configuration registers
  logic [15:0]    block_len_q;
  logic [31:0]    phase_step_q;
  logic [WW-1:0]  window_len_q;
  logic [15:0]    oldest_q;

  swtc_pkg::state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0]     x_q;
  logic [2:0]                        op_q;
  logic                              remove_q;
  logic [31:0]                       ph_q;
  logic signed [15:0]                ref_s_q, ref_c_q;
  logic signed [PRW-1:0]             mul_q;
  logic signed [swtc_pkg::ACC_W-1:0] sacc_q, cacc_q;
  logic [swtc_pkg::EN_W-1:0]         sen_q, cen_q;
  logic [15:0]                       bidx_q;
  logic [PW-1:0]                     pos_q;
  logic [WW-1:0]                     fill_q;
  logic                              vres_q;
  logic [swtc_pkg::SQ_W-1:0]         sq_q;
  logic [swtc_pkg::AMP_W-1:0]        amp_q;
  logic                              m_valid_q;
  logic [swtc_pkg::AMP_W-1:0]        m_data_q;
  logic                              m_user_q;

  logic                              in_fire, cfg_fire, out_load;
  logic                              div_start, sqrt_start, ram_we;
  logic [WW-1:0]                     win_eff;
  logic                              remove_now;
  logic signed [SAMPLE_BITS-1:0]     old_sample;
  logic [47:0]                       ph_full;
  logic [TABLE_BITS-1:0]             k_sin, k_cos;
  logic signed [15:0]                ref_sel;
  logic signed [MB-1:0]              op_b;
  logic signed [PRW-1:0]             mul_d;
  logic [WW-1:0]                     fill_next;
  logic                              valid_next;
  logic [swtc_pkg::SQ_W-1:0]         sq_term;
  logic [swtc_pkg::SQ_W-1:0]         sq_sum;
  logic [swtc_pkg::QUO_W-1:0]        sq_op;
  swtc_pkg::unit_res_t               sdiv_res, cdiv_res, sqrt_res;
  logic [15:0]                       qrom [QN+1];

  // quarter-wave sine table, constant
  for (genvar g = 0; g <= QN; g++) begin : g_rom
    assign qrom[g] = swtc_pkg::quarter_sin(g, TABLE_BITS);
  end

  function automatic logic signed [15:0] rom_lookup(input logic [TABLE_BITS-1:0] k);
    logic [1:0]            quad;
    logic [TABLE_BITS-2:0] u;
    logic [TABLE_BITS-2:0] arg;
    logic signed [15:0]    v;
    quad = k[TABLE_BITS-1 -: 2];
    u    = {1'b0, k[TABLE_BITS-3:0]};
    arg  = quad[0] ? ((TABLE_BITS-1)'(QN) - u) : u;
    v    = signed'(qrom[arg]);
    return quad[1] ? -v : v;
  endfunction

  function automatic logic [15:0] advance(input logic [15:0] idx, input logic [15:0] len);
    logic [15:0] n;
    n = idx + 16'd1;
    return (n >= len) ? 16'd0 : n;
  endfunction

  function automatic logic signed [swtc_pkg::ACC_W-1:0] sat_acc(
    input logic signed [swtc_pkg::ACC_W-1:0] a,
    input logic signed [PRW-1:0]             p,
    input logic                              sub
  );
    logic signed [swtc_pkg::ACC_W:0] pe;
    logic signed [swtc_pkg::ACC_W:0] sum;
    pe  = (swtc_pkg::ACC_W+1)'(p);
    sum = (swtc_pkg::ACC_W+1)'(a) + (sub ? -pe : pe);
    if (sum[swtc_pkg::ACC_W] != sum[swtc_pkg::ACC_W-1]) begin
      return sum[swtc_pkg::ACC_W] ? {1'b1, {(swtc_pkg::ACC_W-1){1'b0}}}
                                  : {1'b0, {(swtc_pkg::ACC_W-1){1'b1}}};
    end
    return sum[swtc_pkg::ACC_W-1:0];
  endfunction

  function automatic logic [swtc_pkg::EN_W-1:0] sat_en(
    input logic [swtc_pkg::EN_W-1:0] e,
    input logic [30:0]               p,
    input logic                      sub
  );
    logic [swtc_pkg::EN_W:0] pe;
    logic [swtc_pkg::EN_W:0] sum;
    pe = {18'd0, p};
    if (sub) begin
      return ({1'b0, e} < pe) ? '0 : swtc_pkg::EN_W'({1'b0, e} - pe);
    end
    sum = {1'b0, e} + pe;
    return (sum > EN_MAX) ? EN_MAX[swtc_pkg::EN_W-1:0] : sum[swtc_pkg::EN_W-1:0];
  endfunction

  // handshakes and window bookkeeping
  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign cfg_fire   = cfg_valid_i && cfg_ready_o;
  assign out_load   = (state_q == swtc_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);
  assign win_eff    = (32'(window_len_q) > 32'(WINDOW_MAX)) ? WW'(WINDOW_MAX) : window_len_q;
  assign remove_now = (win_eff != '0) && (fill_q >= win_eff);
  assign fill_next  = remove_q ? fill_q
                    : ((fill_q < swtc_pkg::FILL_MAX) ? fill_q + WW'(1) : fill_q);
  assign valid_next = ((win_eff == '0) || (fill_next >= win_eff))
                    && (sen_q != '0) && (cen_q != '0);

  // reference phase and table address
  assign ph_full = (op_q[2] ? oldest_q : bidx_q) * phase_step_q;
  assign k_sin   = ph_q[31 -: TABLE_BITS];
  assign k_cos   = k_sin + TABLE_BITS'(QN);

  // shared product: op bit 0 picks cosine, bit 1 squares the reference, else bit 2 takes the oldest sample
  always_comb begin
    ref_sel = op_q[0] ? ref_c_q : ref_s_q;
    if (op_q[1]) begin
      op_b = MB'(ref_sel);
    end else if (op_q[2]) begin
      op_b = MB'(old_sample);
    end else begin
      op_b = MB'(x_q);
    end
    mul_d = PRW'(ref_sel) * PRW'(op_b);
  end

  // squares of the normalized components and their sum
  assign sq_op   = (state_q == swtc_pkg::ST_SQ0) ? sdiv_res.value : cdiv_res.value;
  assign sq_term = swtc_pkg::SQ_W'(sq_op) * swtc_pkg::SQ_W'(sq_op);
  assign sq_sum  = sq_q + sq_term;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swtc_pkg::ST_IDLE:  if (in_fire) state_d = swtc_pkg::ST_PHASE;
      swtc_pkg::ST_PHASE: state_d = swtc_pkg::ST_ROM;
      swtc_pkg::ST_ROM:   state_d = swtc_pkg::ST_MUL;
      swtc_pkg::ST_MUL:   state_d = swtc_pkg::ST_ACC;
      swtc_pkg::ST_ACC: begin
        if (op_q[1:0] != 2'd3) begin
          state_d = swtc_pkg::ST_MUL;
        end else if (!op_q[2] && remove_q) begin
          state_d = swtc_pkg::ST_PHASE;
        end else begin
          state_d = swtc_pkg::ST_FIN;
        end
      end
      swtc_pkg::ST_FIN:   state_d = valid_next ? swtc_pkg::ST_DIV : swtc_pkg::ST_OUT;
      swtc_pkg::ST_DIV:   if (sdiv_res.done && cdiv_res.done) state_d = swtc_pkg::ST_SQ0;
      swtc_pkg::ST_SQ0:   state_d = swtc_pkg::ST_SQ1;
      swtc_pkg::ST_SQ1:   state_d = swtc_pkg::ST_ROOT;
      swtc_pkg::ST_ROOT:  if (sqrt_res.done) state_d = swtc_pkg::ST_OUT;
      swtc_pkg::ST_OUT:   if (out_load) state_d = swtc_pkg::ST_IDLE;
      default:            state_d = swtc_pkg::ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == swtc_pkg::ST_IDLE);
    div_start     = (state_q == swtc_pkg::ST_FIN) && valid_next;
    sqrt_start    = (state_q == swtc_pkg::ST_SQ1);
    ram_we        = (state_q == swtc_pkg::ST_FIN) && (win_eff != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swtc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers and per-sample state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_len_q  <= 16'd1;
      phase_step_q <= '0;
      window_len_q <= '0;
      oldest_q     <= '0;
      bidx_q       <= '0;
      pos_q        <= '0;
      fill_q       <= '0;
      sacc_q       <= '0;
      cacc_q       <= '0;
      sen_q        <= '0;
      cen_q        <= '0;
      op_q         <= '0;
      remove_q     <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index_i)
          swtc_pkg::CFG_BLOCK_LEN:  block_len_q  <= cfg_data_i[15:0];
          swtc_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data_i;
          swtc_pkg::CFG_WINDOW_LEN: window_len_q <= cfg_data_i[WW-1:0];
          swtc_pkg::CFG_LAG_START:  oldest_q     <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        op_q     <= '0;
        remove_q <= remove_now;
      end
      if (state_q == swtc_pkg::ST_ACC) begin
        op_q <= op_q + 3'd1;
        case (op_q[1:0])
          2'd0:    sacc_q <= sat_acc(sacc_q, mul_q, op_q[2]);
          2'd1:    cacc_q <= sat_acc(cacc_q, mul_q, op_q[2]);
          2'd2:    sen_q  <= sat_en(sen_q, mul_q[30:0], op_q[2]);
          default: cen_q  <= sat_en(cen_q, mul_q[30:0], op_q[2]);
        endcase
      end
      if (state_q == swtc_pkg::ST_FIN) begin
        fill_q   <= fill_next;
        bidx_q   <= advance(bidx_q, block_len_q);
        oldest_q <= advance(oldest_q, block_len_q);
        if (win_eff != '0) begin
          pos_q <= ((WW+1)'(pos_q) + (WW+1)'(1) >= (WW+1)'(win_eff)) ? '0 : pos_q + PW'(1);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= signed'(s_axis_tdata[SAMPLE_BITS-1:0]);
    end
    if (state_q == swtc_pkg::ST_PHASE) begin
      ph_q <= ph_full[31:0];
    end
    if (state_q == swtc_pkg::ST_ROM) begin
      ref_s_q <= rom_lookup(k_sin);
      ref_c_q <= rom_lookup(k_cos);
    end
    if (state_q == swtc_pkg::ST_MUL) begin
      mul_q <= mul_d;
    end
    if (state_q == swtc_pkg::ST_FIN) begin
      vres_q <= valid_next;
      amp_q  <= '0;
    end
    if (state_q == swtc_pkg::ST_SQ0) begin
      sq_q <= sq_term;
    end
    if ((state_q == swtc_pkg::ST_ROOT) && sqrt_res.done) begin
      amp_q <= (sqrt_res.value > swtc_pkg::QUO_W'({swtc_pkg::AMP_W{1'b1}}))
             ? {swtc_pkg::AMP_W{1'b1}} : sqrt_res.value[swtc_pkg::AMP_W-1:0];
    end
    if (out_load) begin
      m_data_q <= amp_q;
      m_user_q <= vres_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;
  assign cfg_ready_o     = 1'b1;

  // sample window store
  swtc_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (x_q),
    .raddr_i (pos_q),
    .rdata_o (old_sample)
  );

  swtc_div u_sdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .acc_i   (sacc_q),
    .den_i   (sen_q),
    .res_o   (sdiv_res)
  );

  swtc_div u_cdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .acc_i   (cacc_q),
    .den_i   (cen_q),
    .res_o   (cdiv_res)
  );

  swtc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sq_sum),
    .res_o   (sqrt_res)
  );

endmodule

/* hw/rtl/swtc_ram.sv */
// generic simple dual-port ram with registered read
// no dependencies
module swtc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/swtc_div.sv */
// bit-serial normalizing divider: floor(|acc| * 2^23 / den), capped at 2^25
// depends on swtc_pkg
module swtc_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [swtc_pkg::ACC_W-1:0]    acc_i,
  input  logic [swtc_pkg::EN_W-1:0]            den_i,
  output swtc_pkg::unit_res_t                  res_o
);

  localparam int unsigned QB = swtc_pkg::QUO_W - 1;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [4:0]                      cnt_q, cnt_d;
  logic [swtc_pkg::EN_W-1:0]       rem_q, rem_d;
  logic [QB-1:0]                   sh_q, sh_d;
  logic [swtc_pkg::QUO_W-1:0]      quo_q, quo_d;
  logic [swtc_pkg::ACC_W-1:0]      mag;
  logic [swtc_pkg::EN_W:0]         trial;
  logic                            qbit;

  // magnitude and one restoring step
  always_comb begin
    mag   = acc_i[swtc_pkg::ACC_W-1] ? (~acc_i + 64'd1) : acc_i;
    trial = {rem_q, sh_q[QB-1]};
    qbit  = (trial >= {1'b0, den_i});
  end

  // sequencing of the quotient bits
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quo_d  = quo_q;
    if (start_i) begin
      done_d = 1'b0;
      cnt_d  = '0;
      quo_d  = '0;
      if (mag >= {14'd0, den_i, 2'b00}) begin
        quo_d  = swtc_pkg::QUO_W'(1) << QB;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        rem_d  = mag[swtc_pkg::EN_W+1:2];
        sh_d   = {mag[1:0], 23'd0};
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = qbit ? swtc_pkg::EN_W'(trial - {1'b0, den_i}) : trial[swtc_pkg::EN_W-1:0];
      quo_d = {quo_q[swtc_pkg::QUO_W-2:0], qbit};
      sh_d  = {sh_q[QB-2:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(QB - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    quo_q <= quo_d;
  end

  assign res_o.done  = done_q;
  assign res_o.value = quo_q;

endmodule

/* hw/rtl/swtc_sqrt.sv */
// serial integer square root, two radicand bits per cycle
// depends on swtc_pkg
module swtc_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [swtc_pkg::SQ_W-1:0]   val_i,
  output swtc_pkg::unit_res_t         res_o
);

  localparam int unsigned W = swtc_pkg::SQ_W;

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [W-1:0]   v_q, v_d;
  logic [W-1:0]   r_q, r_d;
  logic [W-1:0]   b_q, b_d;
  logic [W-1:0]   rb;

  // one digit of the root per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    rb     = r_q + b_q;
    if (start_i) begin
      v_d    = val_i;
      r_d    = '0;
      b_d    = W'(1) << (W - 2);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (v_q >= rb) begin
        v_d = v_q - rb;
        r_d = (r_q >> 1) + b_q;
      end else begin
        r_d = r_q >> 1;
      end
      b_d = b_q >> 2;
      if (b_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign res_o.done  = done_q;
  assign res_o.value = r_q[swtc_pkg::QUO_W-1:0];

endmodule

/* hw/rtl/swtc_checker.sv */
// port-level checks of the tone correlator, bound to the top level
// depends on assert_macros.svh and sliding_window_tone_correlator
`include "assert_macros.svh"

module swtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // a stalled result holds its value
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // an invalid result carries zero amplitude
  `ASSERT_SAME(a_inval_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0],
               m_axis_tdata == 24'd0)
  // one sample in work at a time
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
               !s_axis_tready)

endmodule

bind sliding_window_tone_correlator swtc_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
